// ----- hw/rtl/amx_pkg.sv -----
// ----------------------------------------------------------------------------
// amx_pkg
// Shared defaults and types for the affine 3x4 matrix inverse block.
// ----------------------------------------------------------------------------
package amx_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Control and status that travel with one result row.
  typedef struct packed {
    logic [1:0] row_index;
    logic       last_row;
    logic       singular;
  } amx_tag_t;

endpackage

// ----- hw/rtl/affine_matrix3x4_inverse_top.sv -----
// ----------------------------------------------------------------------------
// affine_matrix3x4_inverse_top
// Inverse of a 3x4 affine matrix in signed fixed point, one row per word.
// ----------------------------------------------------------------------------
// Each input word carries a 3x4 affine matrix [A | t]; the block returns three
// words, rows 0, 1 and 2 of the inverse [inv(A) | -inv(A)*t], each element
// rounded to nearest (ties away from zero) and saturated to the word range.
// A zero determinant gives three zero rows with the singular flag set.
// A single shared bit-serial multiplier forms the adjugate, determinant and
// translation products one multiplier bit per cycle, and a restoring divider
// produces one quotient bit per cycle for each of the twelve output elements.
// The default format is Q16.16. A two-word queue at the input lets the next
// matrix arrive while the current one is being worked on, and an output
// register lets the engine move on while a finished row waits.
module affine_matrix3x4_inverse_top #(
  parameter int FRAC_BITS  = amx_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = amx_pkg::WORD_WIDTH_DEF,
  parameter int IN_TW      = ((12 * WORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_TW     = ((4 * WORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // in_r0_c0, in_r0_c1, in_r0_c2, in_r0_c3, in_r1_c0 .. in_r1_c3,
  // in_r2_c0 .. in_r2_c3, each WORD_WIDTH bits, from the lowest bit up.
  input  logic [IN_TW-1:0]  s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // out_c0, out_c1, out_c2, out_c3, each WORD_WIDTH bits, lowest bit up.
  output logic [OUT_TW-1:0] m_tdata,
  // last_row: high on the third row of each matrix.
  output logic              m_tlast,
  // row_index (2 bits), then singular (1 bit), from the lowest bit up.
  output logic [2:0]        m_tuser
);
  import amx_pkg::*;

  logic                      mat_valid;
  logic [12*WORD_WIDTH-1:0]  mat;
  logic                      mat_pop;
  logic                      res_valid;
  logic                      res_ready;
  logic [4*WORD_WIDTH-1:0]   res_data;
  amx_tag_t                  res_tag;

  // Front end: matrix queue.
  amx_front #(
    .WORD_WIDTH (WORD_WIDTH),
    .IN_TW      (IN_TW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .mat_valid (mat_valid),
    .mat       (mat),
    .mat_pop   (mat_pop)
  );

  // Back end: arithmetic sequencer.
  amx_engine #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat       (mat),
    .mat_pop   (mat_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .res_tag   (res_tag)
  );

  // Output register toward the downstream side.
  amx_outbuf #(
    .WORD_WIDTH (WORD_WIDTH),
    .OUT_TW     (OUT_TW)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .res_tag   (res_tag),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- hw/rtl/amx_front.sv -----
// ----------------------------------------------------------------------------
// amx_front
// Input side: accepts matrix words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module amx_front #(
  parameter int WORD_WIDTH = amx_pkg::WORD_WIDTH_DEF,
  parameter int IN_TW      = ((12 * amx_pkg::WORD_WIDTH_DEF + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TW-1:0]          s_tdata,
  output logic                      mat_valid,
  output logic [12*WORD_WIDTH-1:0]  mat,
  input  logic                      mat_pop
);
  import amx_pkg::*;

  localparam int MW = 12 * WORD_WIDTH;

  logic [MW-1:0] ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign mat_valid = (count != 2'd0);
  assign mat       = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= s_tdata[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (mat_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !mat_pop) begin
        count <= count + 2'd1;
      end else if (!push && mat_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/amx_engine.sv -----
// ----------------------------------------------------------------------------
// amx_engine
// Back end: serial multiply-accumulate for adjugate, determinant and
// translation, then, unless singular, a one-bit-per-cycle divider per output element.
// ----------------------------------------------------------------------------
module amx_engine #(
  parameter int FRAC_BITS  = amx_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = amx_pkg::WORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mat_valid,
  input  logic [12*WORD_WIDTH-1:0]  mat,
  output logic                      mat_pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [4*WORD_WIDTH-1:0]   res_data,
  output amx_pkg::amx_tag_t         res_tag
);
  import amx_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AW = 3 * W + 4;
  localparam int NW = AW + 2 * F;
  localparam int CW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADJ  = 3'd1;
  localparam logic [2:0] ST_DET  = 3'd2;
  localparam logic [2:0] ST_DIVL = 3'd3;
  localparam logic [2:0] ST_TACC = 3'd4;
  localparam logic [2:0] ST_DIVT = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  localparam logic [W+1:0] LIM     = (W + 2)'(1) << (W - 1);
  localparam logic [W+1:0] LIM_M1  = LIM - (W + 2)'(1);
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] NEG_MAX = {1'b1, {(W - 1){1'b0}}};

  // Element sources of each cofactor x*y - u*v, as row*4+col.
  localparam logic [3:0] COF_SRC [9][4] = '{
    '{4'd5, 4'd10, 4'd9, 4'd6},
    '{4'd9, 4'd2,  4'd1, 4'd10},
    '{4'd1, 4'd6,  4'd5, 4'd2},
    '{4'd8, 4'd6,  4'd4, 4'd10},
    '{4'd0, 4'd10, 4'd8, 4'd2},
    '{4'd4, 4'd2,  4'd0, 4'd6},
    '{4'd4, 4'd9,  4'd8, 4'd5},
    '{4'd8, 4'd1,  4'd0, 4'd9},
    '{4'd0, 4'd5,  4'd4, 4'd1}
  };

  logic [2:0]    state;
  logic          ld;
  logic [CW-1:0] bitc;
  logic [3:0]    k;
  logic [1:0]    term;
  logic [1:0]    row;
  logic [1:0]    col;

  logic [W-1:0]  m [12];
  logic [AW-1:0] adj [9];
  logic [AW-1:0] acc;
  logic [AW-1:0] mxs;
  logic [W-1:0]  me;
  logic          sub;

  logic [AW-1:0] sel_x;
  logic [W-1:0]  sel_e;
  logic          sel_sub;
  logic [3:0]    ia;
  logic [3:0]    ib;

  logic          last_bit;
  logic [AW-1:0] addend;
  logic [AW-1:0] mac_sum;
  logic [AW-1:0] mac_abs;

  logic [AW-1:0] dmag;
  logic          dneg;
  logic          sing;

  logic [AW-1:0] src;
  logic [AW-1:0] smag;
  logic [NW-1:0] dv_load;
  logic [NW-1:0] dv;
  logic [AW-1:0] r;
  logic [W:0]    q;
  logic          big;
  logic          qneg;
  logic [AW:0]   rs;
  logic [AW:0]   rdiff;
  logic          ge;
  logic [AW-1:0] r_next;
  logic          rup;
  logic [W+1:0]  qr;
  logic [W-1:0]  sat;
  logic [W-1:0]  res [4];

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      m[i] = mat[i*W +: W];
    end
  end

  // Operand selection for the serial multiplier.
  always_comb begin
    sel_x   = '0;
    sel_e   = '0;
    sel_sub = 1'b0;
    ia      = '0;
    ib      = '0;
    unique case (state)
      ST_ADJ: begin
        ia      = COF_SRC[k][{term[0], 1'b0}];
        ib      = COF_SRC[k][{term[0], 1'b1}];
        sel_x   = {{(AW - W){m[ia][W-1]}}, m[ia]};
        sel_e   = m[ib];
        sel_sub = term[0];
      end
      ST_DET: begin
        sel_x = adj[4'(term * 3)];
        sel_e = m[4'(term)];
      end
      ST_TACC: begin
        sel_x   = adj[4'(row * 3 + term)];
        sel_e   = m[4'(term * 4 + 3)];
        sel_sub = 1'b1;
      end
      default: begin
        sel_x = '0;
      end
    endcase
  end

  // The top bit of a signed multiplier has negative weight.
  assign last_bit = (bitc == CW'(W - 1));
  assign addend   = me[0] ? mxs : '0;
  assign mac_sum  = (sub ^ last_bit) ? (acc - addend) : (acc + addend);
  assign mac_abs  = mac_sum[AW-1] ? (~mac_sum + AW'(1)) : mac_sum;

  // Divider operand and one restoring step.
  assign src     = (state == ST_DIVL) ? adj[4'(row * 3 + col)] : acc;
  assign smag    = src[AW-1] ? (~src + AW'(1)) : src;
  assign dv_load = (state == ST_DIVL) ? {smag, {(2 * F){1'b0}}}
                                      : {{F{1'b0}}, smag, {F{1'b0}}};
  assign rs      = {r, dv[NW-1]};
  assign rdiff   = rs - {1'b0, dmag};
  assign ge      = (rs >= {1'b0, dmag});
  assign r_next  = ge ? rdiff[AW-1:0] : rs[AW-1:0];

  // Round to nearest with ties away from zero, then saturate.
  assign rup = ({r, 1'b0} >= {1'b0, dmag});
  assign qr  = {1'b0, q} + (W + 2)'(rup);

  always_comb begin
    if (qneg) begin
      sat = (big || (qr > LIM)) ? NEG_MAX : (~qr[W-1:0] + W'(1));
    end else begin
      sat = (big || (qr > LIM_M1)) ? POS_MAX : qr[W-1:0];
    end
  end

  assign res_valid         = (state == ST_EMIT);
  assign res_data          = {res[3], res[2], res[1], res[0]};
  assign res_tag.row_index = row;
  assign res_tag.last_row  = (row == 2'd2);
  assign res_tag.singular  = sing;
  assign mat_pop           = (state == ST_EMIT) && res_ready && (row == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ld    <= 1'b0;
      bitc  <= '0;
      k     <= '0;
      term  <= '0;
      row   <= '0;
      col   <= '0;
      sing  <= 1'b0;
    end else begin
      unique case (state) inside
        ST_IDLE: begin
          if (mat_valid) begin
            state <= ST_ADJ;
            k     <= '0;
            term  <= '0;
            ld    <= 1'b1;
            acc   <= '0;
          end
        end
        ST_ADJ, ST_DET, ST_TACC: begin
          if (ld) begin
            mxs  <= sel_x;
            me   <= sel_e;
            sub  <= sel_sub;
            bitc <= '0;
            ld   <= 1'b0;
          end else begin
            acc  <= mac_sum;
            mxs  <= mxs << 1;
            me   <= me >> 1;
            bitc <= bitc + CW'(1);
            if (last_bit) begin
              ld <= 1'b1;
              if (state == ST_ADJ) begin
                if (term == 2'd0) begin
                  term <= 2'd1;
                end else begin
                  adj[k] <= mac_sum;
                  term   <= 2'd0;
                  acc    <= '0;
                  if (k == 4'd8) begin
                    state <= ST_DET;
                  end else begin
                    k <= k + 4'd1;
                  end
                end
              end else if (state == ST_DET) begin
                if (term == 2'd2) begin
                  dmag <= mac_abs;
                  dneg <= mac_sum[AW-1];
                  sing <= (mac_sum == '0);
                  row  <= '0;
                  col  <= '0;
                  term <= '0;
                  if (mac_sum == '0) begin
                    for (int i = 0; i < 4; i++) begin
                      res[i] <= '0;
                    end
                    ld    <= 1'b0;
                    state <= ST_EMIT;
                  end else begin
                    state <= ST_DIVL;
                  end
                end else begin
                  term <= term + 2'd1;
                end
              end else begin
                if (term == 2'd2) begin
                  term  <= '0;
                  state <= ST_DIVT;
                end else begin
                  term <= term + 2'd1;
                end
              end
            end
          end
        end
        ST_DIVL, ST_DIVT: begin
          if (ld) begin
            dv   <= dv_load;
            r    <= '0;
            q    <= '0;
            big  <= 1'b0;
            qneg <= src[AW-1] ^ dneg;
            bitc <= '0;
            ld   <= 1'b0;
          end else if (bitc != CW'(NW)) begin
            r    <= r_next;
            dv   <= dv << 1;
            q    <= {q[W-1:0], ge};
            big  <= big | q[W];
            bitc <= bitc + CW'(1);
          end else if (state == ST_DIVL) begin
            res[col] <= sat;
            ld       <= 1'b1;
            if (col == 2'd2) begin
              state <= ST_TACC;
              term  <= '0;
              acc   <= '0;
            end else begin
              col <= col + 2'd1;
            end
          end else begin
            res[3] <= sat;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (res_ready) begin
            if (row == 2'd2) begin
              state <= ST_IDLE;
            end else begin
              row <= row + 2'd1;
              if (!sing) begin
                col   <= '0;
                ld    <= 1'b1;
                state <= ST_DIVL;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/amx_outbuf.sv -----
// ----------------------------------------------------------------------------
// amx_outbuf
// Output register: holds one row word for the downstream side.
// ----------------------------------------------------------------------------
module amx_outbuf #(
  parameter int WORD_WIDTH = amx_pkg::WORD_WIDTH_DEF,
  parameter int OUT_TW     = ((4 * amx_pkg::WORD_WIDTH_DEF + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_valid,
  output logic                     res_ready,
  input  logic [4*WORD_WIDTH-1:0]  res_data,
  input  amx_pkg::amx_tag_t        res_tag,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_TW-1:0]        m_tdata,
  output logic                     m_tlast,
  output logic [2:0]               m_tuser
);
  import amx_pkg::*;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OUT_TW'(res_data);
      m_tlast <= res_tag.last_row;
      m_tuser <= {res_tag.singular, res_tag.row_index};
    end
  end

endmodule
